### sv/ppjs_pkg.sv
// ----------------------------------------------------------------------------
// ppjs_pkg: shared types and constants of the priority job scheduler
// Holds the queue entry layout, operation and result codes, and time limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ppjs_pkg;

	localparam int TIME_W = 48;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam int WORK_W = 31;
	localparam int ID_W = 16;
	localparam int PRIO_W = 16;

	// At most this many results come from one input item.
	localparam int RESULT_LIMIT = 32;
	localparam int RES_CNT_W = $clog2(RESULT_LIMIT + 1);

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [WORK_W-1:0] rem;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### sv/preemptive_priority_job_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_job_scheduler: single-server preemptive priority queue
//
// Usage: an item transfers at a rising edge with start high and busy low.
// opcode 0 is a job arrival: the time since the last event is spent on the
// queued jobs, highest priority first (ties to the earlier arrival), and then
// the new job is queued, or rejected with kind 1 when the queue is full.
// opcode 1 drains the queue, finishing every job in priority order.
// Each result is shown for one cycle with result_valid high; the receiver
// cannot stall it. last marks the final result of an item. An item that
// causes no result shows nothing.
// Each service step scans the queued entries for the highest priority in
// sequence through the one RAM read port; when the job finishes, every entry
// queued behind it is moved down one place through the same port. Results
// trail their job by one service step. The block takes no new item while
// busy is high.
// Reset clears the queue count and the clock; queue contents need no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_job_scheduler
	import ppjs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              opcode,
	input  wire logic [WORK_W-1:0] arrival_time,
	input  wire logic [WORK_W-1:0] work,
	input  wire logic [PRIO_W-1:0] priority_req,
	input  wire logic [ID_W-1:0]   job_id,
	output logic                   busy,
	output logic                   result_valid,
	output logic                   kind,
	output logic [ID_W-1:0]        done_id,
	output logic [TIME_W-1:0]      finish_time,
	output logic                   last
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOP,
		ST_SCAN,
		ST_DECIDE,
		ST_SH_RD,
		ST_SH_WR,
		ST_ENQ,
		ST_FLUSH
	} state_t;

	state_t state_q;

	logic                 op_q;
	logic [WORK_W-1:0]    at_q;
	logic [WORK_W-1:0]    work_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [ID_W-1:0]      id_q;
	logic [WORK_W-1:0]    gap_q;
	logic [TIME_W-1:0]    cur_q;
	logic [CW-1:0]        count_q;
	logic [RES_CNT_W-1:0] n_q;

	logic [CW-1:0]        scan_q;
	logic                 rd_vld_s1;
	logic [CW-1:0]        rd_idx_s1;
	entry_t               best_q;
	logic [CW-1:0]        best_idx_q;
	logic [CW-1:0]        ptr_q;

	logic                 pend_vld_q;
	logic                 pend_kind_q;
	logic [ID_W-1:0]      pend_id_q;
	logic [TIME_W-1:0]    pend_time_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	entry_t               ram_wdata;
	logic [AW-1:0]        ram_raddr;
	entry_t               ram_rdata;

	logic                 fin_job;
	logic [TIME_W:0]      time_sum;
	logic [TIME_W-1:0]    sat_time;
	logic                 at_ahead;
	logic                 loop_go;
	logic                 queue_full;
	logic                 can_emit;

	ppjs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		fin_job = (op_q == OP_DRAIN) || (gap_q >= best_q.rem);
		time_sum = {1'b0, cur_q} + {{(TIME_W + 1 - WORK_W){1'b0}}, best_q.rem};
		sat_time = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
		at_ahead = {{(TIME_W - WORK_W){1'b0}}, at_q} > cur_q;
		can_emit = n_q < RES_CNT_W'(RESULT_LIMIT);
		queue_full = count_q >= CW'(QUEUE_DEPTH);
		loop_go = (count_q != '0) && can_emit && ((op_q == OP_DRAIN) || (gap_q != '0));
	end

	// RAM port control: the scan and the shift share the read port.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = best_idx_q[AW-1:0];
		ram_wdata = best_q;
		ram_raddr = scan_q[AW-1:0];
		unique case (state_q)
			ST_DECIDE: begin
				if (!fin_job) begin
					ram_we = 1'b1;
					ram_wdata.rem = best_q.rem - gap_q;
				end
			end
			ST_SH_RD: begin
				ram_raddr = AW'(ptr_q + 1'b1);
			end
			ST_SH_WR: begin
				ram_we = 1'b1;
				ram_waddr = ptr_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			ST_ENQ: begin
				if (!queue_full) begin
					ram_we = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = '{id: id_q, rem: work_q, prio: prio_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy <= 1'b0;
			result_valid <= 1'b0;
			kind <= KIND_DONE;
			done_id <= '0;
			finish_time <= '0;
			last <= 1'b0;
			op_q <= OP_ARRIVAL;
			at_q <= '0;
			work_q <= '0;
			prio_q <= '0;
			id_q <= '0;
			gap_q <= '0;
			cur_q <= '0;
			count_q <= '0;
			n_q <= '0;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			best_q <= '0;
			best_idx_q <= '0;
			ptr_q <= '0;
			pend_vld_q <= 1'b0;
			pend_kind_q <= KIND_DONE;
			pend_id_q <= '0;
			pend_time_q <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= opcode;
						at_q <= arrival_time;
						work_q <= work;
						prio_q <= priority_req;
						id_q <= job_id;
						n_q <= '0;
						// The gap is nonzero only when the clock is below a 31-bit time.
						if ({{(TIME_W - WORK_W){1'b0}}, arrival_time} > cur_q) begin
							gap_q <= arrival_time - cur_q[WORK_W-1:0];
						end else begin
							gap_q <= '0;
						end
						busy <= 1'b1;
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					scan_q <= '0;
					rd_vld_s1 <= 1'b0;
					if (loop_go) begin
						state_q <= ST_SCAN;
					end else if (op_q == OP_ARRIVAL) begin
						state_q <= ST_ENQ;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_SCAN: begin
					if (scan_q < count_q) begin
						scan_q <= scan_q + 1'b1;
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= scan_q;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (rd_vld_s1) begin
						// Strictly greater wins, so the earliest entry keeps a tie.
						if (rd_idx_s1 == '0 || ram_rdata.prio > best_q.prio) begin
							best_q <= ram_rdata;
							best_idx_q <= rd_idx_s1;
						end
						if (rd_idx_s1 + 1'b1 == count_q) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (fin_job) begin
						gap_q <= gap_q - best_q.rem;
						cur_q <= sat_time;
						n_q <= n_q + 1'b1;
						// A result waits in the pending slot until it is known
						// whether another one follows.
						if (pend_vld_q) begin
							result_valid <= 1'b1;
							kind <= pend_kind_q;
							done_id <= pend_id_q;
							finish_time <= pend_time_q;
							last <= 1'b0;
						end
						pend_vld_q <= 1'b1;
						pend_kind_q <= KIND_DONE;
						pend_id_q <= best_q.id;
						pend_time_q <= sat_time;
						ptr_q <= best_idx_q;
						if (best_idx_q + 1'b1 < count_q) begin
							state_q <= ST_SH_RD;
						end else begin
							count_q <= count_q - 1'b1;
							state_q <= ST_LOOP;
						end
					end else begin
						gap_q <= '0;
						state_q <= ST_LOOP;
					end
				end
				ST_SH_RD: begin
					state_q <= ST_SH_WR;
				end
				ST_SH_WR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q + 2'd2 < count_q) begin
						state_q <= ST_SH_RD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= ST_LOOP;
					end
				end
				ST_ENQ: begin
					if (at_ahead) begin
						cur_q <= {{(TIME_W - WORK_W){1'b0}}, at_q};
					end
					if (queue_full) begin
						if (can_emit) begin
							n_q <= n_q + 1'b1;
							if (pend_vld_q) begin
								result_valid <= 1'b1;
								kind <= pend_kind_q;
								done_id <= pend_id_q;
								finish_time <= pend_time_q;
								last <= 1'b0;
							end
							pend_vld_q <= 1'b1;
							pend_kind_q <= KIND_REJECT;
							pend_id_q <= id_q;
							pend_time_q <= '0;
						end
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (pend_vld_q) begin
						result_valid <= 1'b1;
						kind <= pend_kind_q;
						done_id <= pend_id_q;
						finish_time <= pend_time_q;
						last <= 1'b1;
					end
					pend_vld_q <= 1'b0;
					busy <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/ppjs_ram.sv
// ----------------------------------------------------------------------------
// ppjs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ppjs_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### tb/sv/tb_preemptive_priority_job_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_job_scheduler: self-checking bench of the scheduler
// Mirrors the job queue and the server clock in the bench, predicts every
// completion and rejection for each accepted item, and compares each result
// transfer field by field. Stimulus runs from hand-built cases through a queue
// overflow burst and random traffic to the largest times and amounts of work.
// ----------------------------------------------------------------------------

module tb_preemptive_priority_job_scheduler
	import ppjs_pkg::*;
;

	localparam int DEPTH = 32;
	// Worst case is about 32 jobs per item.
	localparam int CYCLE_LIMIT = 2000000;
	localparam int QUIET_LIMIT = 20000;
	localparam int REPORT_MAX = 10;
	localparam logic [WORK_W-1:0] AT_MAX = {WORK_W{1'b1}};

	typedef struct {
		logic              kind;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] ftime;
		logic              last;
	} completion_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              opcode;
	logic [WORK_W-1:0] arrival_time;
	logic [WORK_W-1:0] work;
	logic [PRIO_W-1:0] priority_req;
	logic [ID_W-1:0]   job_id;
	logic              busy;
	logic              result_valid;
	logic              kind;
	logic [ID_W-1:0]   done_id;
	logic [TIME_W-1:0] finish_time;
	logic              last;

	// Bench copy of the scheduler state.
	entry_t            mirror_jobs [DEPTH];
	int                mirror_cnt;
	logic [TIME_W-1:0] mirror_clock;

	completion_t       completions_q [$];

	logic [WORK_W-1:0] arr_time;
	bit                no_idle;
	int                err_count;
	int                items_sent;
	int                drains_sent;
	int                results_seen;
	int                rejects_seen;
	int                cycle_cnt;

	preemptive_priority_job_scheduler #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(opcode),
		.arrival_time(arrival_time),
		.work(work),
		.priority_req(priority_req),
		.job_id(job_id),
		.busy(busy),
		.result_valid(result_valid),
		.kind(kind),
		.done_id(done_id),
		.finish_time(finish_time),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] clock_add(input logic [TIME_W-1:0] a,
		input logic [WORK_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W + 1)'(b);
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	// Highest priority wins; the strict compare keeps ties on the older job.
	function automatic int top_job();
		int best;
		best = 0;
		for (int i = 1; i < mirror_cnt; i++)
			if (mirror_jobs[i].prio > mirror_jobs[best].prio)
				best = i;
		return best;
	endfunction

	function automatic void drop_job(input int k);
		for (int i = k; i < mirror_cnt - 1; i++)
			mirror_jobs[i] = mirror_jobs[i + 1];
		mirror_cnt--;
	endfunction

	function automatic void log_completion(input logic k, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] t);
		completion_t c;
		c.kind = k;
		c.id = id;
		c.ftime = t;
		c.last = 1'b0;
		completions_q.push_back(c);
	endfunction

	function automatic void predict_completions(input logic op, input logic [WORK_W-1:0] at,
		input logic [WORK_W-1:0] w, input logic [PRIO_W-1:0] pr, input logic [ID_W-1:0] id);
		logic [TIME_W-1:0] gap;
		logic [TIME_W-1:0] at_wide;
		completion_t       c;
		int                n;
		int                b;
		n = 0;
		at_wide = TIME_W'(at);
		if (op == OP_ARRIVAL) begin
			gap = (at_wide > mirror_clock) ? at_wide - mirror_clock : '0;
			while (gap != 0 && mirror_cnt > 0 && n < RESULT_LIMIT) begin
				b = top_job();
				if (gap >= TIME_W'(mirror_jobs[b].rem)) begin
					gap = gap - TIME_W'(mirror_jobs[b].rem);
					mirror_clock = clock_add(mirror_clock, mirror_jobs[b].rem);
					log_completion(KIND_DONE, mirror_jobs[b].id, mirror_clock);
					drop_job(b);
					n++;
				end else begin
					mirror_jobs[b].rem = mirror_jobs[b].rem - gap[WORK_W-1:0];
					gap = '0;
				end
			end
			if (at_wide > mirror_clock)
				mirror_clock = at_wide;
			if (mirror_cnt >= DEPTH) begin
				if (n < RESULT_LIMIT) begin
					log_completion(KIND_REJECT, id, '0);
					n++;
				end
			end else begin
				mirror_jobs[mirror_cnt].id = id;
				mirror_jobs[mirror_cnt].rem = w;
				mirror_jobs[mirror_cnt].prio = pr;
				mirror_cnt++;
			end
		end else begin
			while (mirror_cnt > 0 && n < RESULT_LIMIT) begin
				b = top_job();
				mirror_clock = clock_add(mirror_clock, mirror_jobs[b].rem);
				log_completion(KIND_DONE, mirror_jobs[b].id, mirror_clock);
				drop_job(b);
				n++;
			end
		end
		if (n > 0) begin
			c = completions_q.pop_back();
			c.last = 1'b1;
			completions_q.push_back(c);
		end
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Drives one item from a falling edge, waits for its transfer, then may idle for a random gap.
	task automatic issue_item(input logic op, input logic [WORK_W-1:0] at,
		input logic [WORK_W-1:0] w, input logic [PRIO_W-1:0] pr, input logic [ID_W-1:0] id);
		int gap;
		start <= 1'b1;
		opcode <= op;
		arrival_time <= at;
		work <= w;
		priority_req <= pr;
		job_id <= id;
		do @(posedge clk); while (busy);
		predict_completions(op, at, w, pr, id);
		items_sent++;
		if (op == OP_DRAIN)
			drains_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			opcode <= 1'($urandom);
			arrival_time <= WORK_W'($urandom);
			work <= WORK_W'($urandom);
			priority_req <= PRIO_W'($urandom);
			job_id <= ID_W'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic issue_drain();
		issue_item(OP_DRAIN, WORK_W'($urandom), WORK_W'($urandom),
			PRIO_W'($urandom), ID_W'($urandom));
	endtask

	task automatic hold_until_quiet(input int settle);
		int waited;
		waited = 0;
		start <= 1'b0;
		while ((completions_q.size() != 0 || busy) && waited < QUIET_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (settle) @(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		completion_t want;
		if (arst_n && result_valid) begin
			results_seen++;
			if (kind == KIND_REJECT)
				rejects_seen++;
			if (completions_q.size() == 0) begin
				note_error($sformatf("unexpected result kind=%0d id=%h time=%0d last=%0d",
					kind, done_id, finish_time, last));
			end else begin
				want = completions_q.pop_front();
				if (kind !== want.kind || done_id !== want.id ||
					finish_time !== want.ftime || last !== want.last)
					note_error($sformatf({"expected kind=%0d id=%h time=%0d last=%0d, ",
						"got kind=%0d id=%h time=%0d last=%0d"},
						want.kind, want.id, want.ftime, want.last,
						kind, done_id, finish_time, last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("preemptive_priority_job_scheduler verification failed");
			$finish;
		end
	end

	// Hand-built sequence: zero work, ties, preemption, partial service,
	// arrivals behind the clock and a drain of an empty queue.
	task automatic test_directed();
		issue_drain();
		issue_item(OP_ARRIVAL, 31'd0, 31'd0, 16'h0000, 16'h0000);
		issue_item(OP_ARRIVAL, 31'd10, 31'd5, 16'hFFFF, 16'hFFFF);
		issue_item(OP_ARRIVAL, 31'd12, 31'd20, 16'd100, 16'd2);
		issue_item(OP_ARRIVAL, 31'd12, 31'd4, 16'd100, 16'd3);
		issue_item(OP_ARRIVAL, 31'd13, 31'd1, 16'hFFFF, 16'd4);
		issue_item(OP_ARRIVAL, 31'd30, 31'd9, 16'd1, 16'd8);
		issue_item(OP_ARRIVAL, 31'd25, 31'd7, 16'd50, 16'd5);
		issue_drain();
		issue_item(OP_ARRIVAL, 31'd40, 31'd3, 16'd7, 16'd6);
		issue_item(OP_ARRIVAL, 31'd100, 31'd2, 16'd7, 16'd7);
		issue_drain();
		issue_drain();
		arr_time = 31'd100;
		hold_until_quiet(8);
	endtask

	// Fills the queue at one instant so that later arrivals are turned away.
	task automatic test_queue_full();
		logic [WORK_W-1:0] base;
		base = arr_time + 31'd1;
		for (int i = 0; i < DEPTH + 2; i++)
			issue_item(OP_ARRIVAL, base, WORK_W'($urandom_range(1, 50)),
				PRIO_W'($urandom_range(0, 7)), ID_W'($urandom));
		issue_item(OP_ARRIVAL, base + 31'd1, WORK_W'($urandom_range(1, 50)),
			PRIO_W'($urandom), ID_W'($urandom));
		issue_item(OP_ARRIVAL, base + 31'd200, WORK_W'($urandom_range(0, 50)),
			PRIO_W'($urandom), ID_W'($urandom));
		issue_drain();
		arr_time = base + 31'd200;
		hold_until_quiet(8);
	endtask

	task automatic test_random(input int count);
		int                roll;
		logic [WORK_W-1:0] at;
		logic [WORK_W-1:0] w;
		logic [PRIO_W-1:0] pr;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (i == count / 2)
				hold_until_quiet(8);
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				issue_drain();
			end else begin
				if (roll < 20 && arr_time > 0) begin
					// Arrival stamped behind the latest one.
					at = arr_time - WORK_W'($urandom_range(1,
						(arr_time > 200) ? 200 : arr_time));
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 20)
						arr_time = arr_time;
					else if (roll < 90)
						arr_time = arr_time + WORK_W'($urandom_range(1, 60));
					else
						arr_time = arr_time + WORK_W'($urandom_range(100, 5000));
					at = arr_time;
				end
				roll = $urandom_range(0, 99);
				if (roll < 10)
					w = '0;
				else if (roll < 90)
					w = WORK_W'($urandom_range(1, 200));
				else
					w = WORK_W'($urandom_range(0, 2000));
				pr = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3))
					: PRIO_W'($urandom);
				issue_item(OP_ARRIVAL, at, w, pr, ID_W'($urandom));
			end
		end
		no_idle = 1'b0;
		hold_until_quiet(8);
	endtask

	// Largest arrival times and amounts of work; the clock runs past 2^31 here.
	task automatic test_extremes();
		issue_item(OP_ARRIVAL, AT_MAX - 31'd1, AT_MAX, 16'hFFFF, ID_W'($urandom));
		issue_item(OP_ARRIVAL, AT_MAX, 31'd1, 16'h0000, ID_W'($urandom));
		issue_item(OP_ARRIVAL, AT_MAX, 31'd0, 16'hFFFF, ID_W'($urandom));
		issue_drain();
		issue_item(OP_ARRIVAL, 31'd0, AT_MAX, PRIO_W'($urandom), ID_W'($urandom));
		issue_item(OP_ARRIVAL, AT_MAX, AT_MAX, PRIO_W'($urandom), ID_W'($urandom));
		issue_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_ARRIVAL;
		arrival_time = '0;
		work = '0;
		priority_req = '0;
		job_id = '0;
		mirror_cnt = 0;
		mirror_clock = '0;
		arr_time = '0;
		no_idle = 1'b0;
		err_count = 0;
		items_sent = 0;
		drains_sent = 0;
		results_seen = 0;
		rejects_seen = 0;
		cycle_cnt = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_queue_full();
		test_random(64);
		test_extremes();

		hold_until_quiet(50);
		if (completions_q.size() != 0)
			note_error($sformatf("%0d expected results never arrived", completions_q.size()));

		$display("Covered %0d items (%0d drains) with %0d result transfers, %0d rejections.",
			items_sent, drains_sent, results_seen, rejects_seen);
		$display("Errors: %0d over %0d cycles.", err_count, cycle_cnt);
		if (err_count == 0)
			$display("preemptive_priority_job_scheduler verification clean");
		else
			$display("preemptive_priority_job_scheduler verification failed");
		$finish;
	end

endmodule

### sim.f
sv/ppjs_pkg.sv
sv/ppjs_ram.sv
sv/preemptive_priority_job_scheduler.sv
tb/sv/tb_preemptive_priority_job_scheduler.sv
